// ===== rtl/core/amrd_pkg.sv =====
// amrd_pkg: widths, angle constants, arctangent table and register codes
// for the angular-map ray direction pipeline. Depends on nothing.
`default_nettype none

package amrd_pkg;

  // field and datapath widths
  localparam int COORD_W  = 16;
  localparam int DIR_W    = 16;
  localparam int SQ_W     = 32;
  localparam int RT_W     = 17;
  localparam int RT_REM_W = 20;
  localparam int ANG_W    = 34;
  localparam int PRD_W    = 50;
  localparam int NUM_W    = 50;
  localparam int DEN_W    = 31;
  localparam int QUO_W    = 18;
  localparam int DZ_W     = 20;
  localparam int RES_W    = 20;
  localparam int ATAN_LEN = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic [NUM_W-1:0]        num_t;
  typedef logic [DEN_W-1:0]        den_t;
  typedef logic [QUO_W-1:0]        quo_t;

  // item fields that ride along the early and middle stages
  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic                      rej;
  } side_t;

  // angles in Q.30
  localparam ang_t TWO_PI_Q30  = 34'sd6746518852;
  localparam ang_t PI_Q30      = 34'sd3373259426;
  localparam ang_t HALF_PI_Q30 = 34'sd1686629713;
  localparam ang_t CORDIC_K    = 34'sd652032874;
  localparam ang_t ROUND_Q15   = 34'sd16384;

  localparam ang_t ATAN_Q30 [ATAN_LEN] = '{
    34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
    34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
    34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
    34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
    34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
    34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F
  };

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_ANGLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVER_RENDER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X    = 3'd4;

  localparam logic [CFG_DAT_W-1:0] HALF_ANGLE_RST = 16'd51472;
  localparam logic [CFG_DAT_W-1:0] LEN_MAX_RST    = 16'd4096;

  localparam logic signed [DIR_W-1:0] DIR_MAX = 16'sh7FFF;
  localparam logic signed [DIR_W-1:0] DIR_MIN = 16'sh8000;
  localparam logic signed [RES_W-1:0] ONE_Q15 = 20'sd32768;

  // clamp a wide signed result to the Q1.15 output range
  function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [RES_W-1:0] v);
    logic signed [DIR_W-1:0] res;
    if (v > RES_W'(DIR_MAX)) begin
      res = DIR_MAX;
    end else if (v < RES_W'(DIR_MIN)) begin
      res = DIR_MIN;
    end else begin
      res = v[DIR_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/amrd_div.sv =====
// amrd_div: pipelined restoring divider, one quotient bit per stage.
// Depends on amrd_pkg for widths.
`default_nettype none

module amrd_div (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire amrd_pkg::num_t num_i,
  input  wire amrd_pkg::den_t den_i,
  output amrd_pkg::quo_t     quo_o
);

  localparam int STEPS = amrd_pkg::QUO_W;

  amrd_pkg::num_t rem_r [STEPS];
  amrd_pkg::num_t rem_nxt [STEPS];
  amrd_pkg::den_t den_r [STEPS];
  amrd_pkg::den_t den_nxt [STEPS];
  amrd_pkg::quo_t quo_r [STEPS];
  amrd_pkg::quo_t quo_nxt [STEPS];

  // each stage tries the divisor at one bit weight, most significant first
  always_comb begin
    amrd_pkg::num_t rem_in;
    amrd_pkg::den_t den_in;
    amrd_pkg::quo_t quo_in;
    amrd_pkg::num_t trial;
    for (int k = 0; k < STEPS; k++) begin
      if (k == 0) begin
        rem_in = num_i;
        den_in = den_i;
        quo_in = '0;
      end else begin
        rem_in = rem_r[k-1];
        den_in = den_r[k-1];
        quo_in = quo_r[k-1];
      end
      trial = amrd_pkg::NUM_W'(den_in) << (STEPS - 1 - k);
      den_nxt[k] = den_in;
      if (rem_in >= trial) begin
        rem_nxt[k] = rem_in - trial;
        quo_nxt[k] = {quo_in[STEPS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rem_in;
        quo_nxt[k] = {quo_in[STEPS-2:0], 1'b0};
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      den_r <= den_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo_o = quo_r[STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/angular_map_ray_direction.sv =====
// Angular-map camera ray direction: screen point in, unit ray out.
// Accepts one transfer per cycle while the output is not stalled; the square root,
// CORDIC and divider each take one bit or one rotation per stage. A stalled output
// holds every stage in place.
// Synchronous reset clears all valid bits and loads the register defaults.
`default_nettype none

module angular_map_ray_direction #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [15:0]        in_screen_x,
  input  wire logic signed [15:0]        in_screen_y,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [15:0]             out_dir_x,
  output logic signed [15:0]             out_dir_y,
  output logic signed [15:0]             out_dir_z,
  output logic                           out_rejected,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [15:0]               cfg_data
);

  localparam int NC = (CORDIC_STEPS < amrd_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                          : amrd_pkg::ATAN_LEN;
  localparam int RT_W  = amrd_pkg::RT_W;
  localparam int QUO_W = amrd_pkg::QUO_W;
  localparam int LAT   = 2 + RT_W + 4 + NC + 2 + QUO_W + 1;

  // configuration registers
  logic [15:0] half_angle_r;
  logic [15:0] len_max_r;
  logic        over_render_r;
  logic        flip_r;
  logic        mirror_x_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_angle_r  <= amrd_pkg::HALF_ANGLE_RST;
      len_max_r     <= amrd_pkg::LEN_MAX_RST;
      over_render_r <= 1'b0;
      flip_r        <= 1'b0;
      mirror_x_r    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        amrd_pkg::REG_HALF_ANGLE:  half_angle_r  <= cfg_data;
        amrd_pkg::REG_LEN_MAX:     len_max_r     <= cfg_data;
        amrd_pkg::REG_OVER_RENDER: over_render_r <= cfg_data[0];
        amrd_pkg::REG_FLIP:        flip_r        <= cfg_data[0];
        amrd_pkg::REG_MIRROR_X:    mirror_x_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline advance and valid bits
  logic [LAT-1:0] vld_r;
  logic           adv;

  assign adv       = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // squares
  logic signed [31:0] sxx_full;
  logic signed [31:0] syy_full;
  logic [30:0]        s0_sxx_r;
  logic [30:0]        s0_syy_r;
  amrd_pkg::side_t    s0_sd_r;

  assign sxx_full = in_screen_x * in_screen_x;
  assign syy_full = in_screen_y * in_screen_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sxx_r   <= sxx_full[30:0];
      s0_syy_r   <= syy_full[30:0];
      s0_sd_r.sx <= in_screen_x;
      s0_sd_r.sy <= in_screen_y;
      s0_sd_r.rej <= 1'b0;
    end
  end

  // squared radius and circle test
  logic [amrd_pkg::SQ_W-1:0] sq_sum;
  logic [amrd_pkg::SQ_W-1:0] s1_sq_r;
  amrd_pkg::side_t           s1_sd_r;

  assign sq_sum = {1'b0, s0_sxx_r} + {1'b0, s0_syy_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sq_r     <= sq_sum;
      s1_sd_r.sx  <= s0_sd_r.sx;
      s1_sd_r.sy  <= s0_sd_r.sy;
      s1_sd_r.rej <= !over_render_r && (sq_sum > {len_max_r, 16'h0000});
    end
  end

  // square root of 4*sq, one root bit per stage
  logic [amrd_pkg::RT_REM_W-1:0] q_rem_r   [RT_W];
  logic [amrd_pkg::RT_REM_W-1:0] q_rem_nxt [RT_W];
  logic [RT_W-1:0]               q_root_r  [RT_W];
  logic [RT_W-1:0]               q_root_nxt[RT_W];
  logic [2*RT_W-1:0]             q_v_r     [RT_W];
  logic [2*RT_W-1:0]             q_v_nxt   [RT_W];
  amrd_pkg::side_t               q_sd_r    [RT_W];
  amrd_pkg::side_t               q_sd_nxt  [RT_W];

  always_comb begin
    logic [amrd_pkg::RT_REM_W-1:0] rem_in;
    logic [RT_W-1:0]               root_in;
    logic [2*RT_W-1:0]             v_in;
    amrd_pkg::side_t               sd_in;
    logic [amrd_pkg::RT_REM_W:0]   rem_sh;
    logic [amrd_pkg::RT_REM_W:0]   trial;
    for (int j = 0; j < RT_W; j++) begin
      if (j == 0) begin
        rem_in  = '0;
        root_in = '0;
        v_in    = {s1_sq_r, 2'b00};
        sd_in   = s1_sd_r;
      end else begin
        rem_in  = q_rem_r[j-1];
        root_in = q_root_r[j-1];
        v_in    = q_v_r[j-1];
        sd_in   = q_sd_r[j-1];
      end
      rem_sh = {rem_in[amrd_pkg::RT_REM_W-2:0], v_in[2*(RT_W-1-j) +: 2]};
      trial  = {2'b00, root_in, 2'b01};
      q_v_nxt[j]  = v_in;
      q_sd_nxt[j] = sd_in;
      if (rem_sh >= trial) begin
        q_rem_nxt[j]  = amrd_pkg::RT_REM_W'(rem_sh - trial);
        q_root_nxt[j] = {root_in[RT_W-2:0], 1'b1};
      end else begin
        q_rem_nxt[j]  = rem_sh[amrd_pkg::RT_REM_W-1:0];
        q_root_nxt[j] = {root_in[RT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_rem_r  <= q_rem_nxt;
      q_root_r <= q_root_nxt;
      q_v_r    <= q_v_nxt;
      q_sd_r   <= q_sd_nxt;
    end
  end

  // angle: theta = half_angle * r * 2
  logic [RT_W-1:0]         root;
  logic [32:0]             theta_prod;
  logic [amrd_pkg::ANG_W-1:0] m_theta_r;
  logic [RT_W-1:0]         m_root_r;
  logic                    m_zero_r;
  amrd_pkg::side_t         m_sd_r;

  assign root       = q_root_r[RT_W-1];
  assign theta_prod = half_angle_r * root;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_theta_r <= {theta_prod, 1'b0};
      m_root_r  <= root;
      m_zero_r  <= (root == '0);
      m_sd_r    <= q_sd_r[RT_W-1];
    end
  end

  // reduce modulo two pi
  logic [amrd_pkg::ANG_W-1:0] two_pi_u;
  logic [amrd_pkg::ANG_W-1:0] pi_u;
  logic [amrd_pkg::ANG_W-1:0] r_t_r;
  logic [RT_W-1:0]            r_root_r;
  logic                       r_zero_r;
  amrd_pkg::side_t            r_sd_r;

  assign two_pi_u = amrd_pkg::TWO_PI_Q30;
  assign pi_u     = amrd_pkg::PI_Q30;

  always_ff @(posedge clk) begin
    if (adv) begin
      r_t_r    <= (m_theta_r >= two_pi_u) ? m_theta_r - two_pi_u : m_theta_r;
      r_root_r <= m_root_r;
      r_zero_r <= m_zero_r;
      r_sd_r   <= m_sd_r;
    end
  end

  // wrap into [-pi, pi]
  amrd_pkg::ang_t  w_t_r;
  logic [RT_W-1:0] w_root_r;
  logic            w_zero_r;
  amrd_pkg::side_t w_sd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      w_t_r    <= (r_t_r > pi_u) ? $signed(r_t_r) - amrd_pkg::TWO_PI_Q30 : $signed(r_t_r);
      w_root_r <= r_root_r;
      w_zero_r <= r_zero_r;
      w_sd_r   <= r_sd_r;
    end
  end

  // fold into [-pi/2, pi/2], keeping the cosine sign
  amrd_pkg::ang_t  f_t_r;
  logic            f_cneg_r;
  logic [RT_W-1:0] f_root_r;
  logic            f_zero_r;
  amrd_pkg::side_t f_sd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (w_t_r > amrd_pkg::HALF_PI_Q30) begin
        f_t_r    <= amrd_pkg::PI_Q30 - w_t_r;
        f_cneg_r <= 1'b1;
      end else if (w_t_r < -amrd_pkg::HALF_PI_Q30) begin
        f_t_r    <= -amrd_pkg::PI_Q30 - w_t_r;
        f_cneg_r <= 1'b1;
      end else begin
        f_t_r    <= w_t_r;
        f_cneg_r <= 1'b0;
      end
      f_root_r <= w_root_r;
      f_zero_r <= w_zero_r;
      f_sd_r   <= w_sd_r;
    end
  end

  // CORDIC rotation, one micro-rotation per stage
  amrd_pkg::ang_t  c_x_r     [NC];
  amrd_pkg::ang_t  c_x_nxt   [NC];
  amrd_pkg::ang_t  c_y_r     [NC];
  amrd_pkg::ang_t  c_y_nxt   [NC];
  amrd_pkg::ang_t  c_t_r     [NC];
  amrd_pkg::ang_t  c_t_nxt   [NC];
  logic            c_cneg_r  [NC];
  logic            c_cneg_nxt[NC];
  logic [RT_W-1:0] c_root_r  [NC];
  logic [RT_W-1:0] c_root_nxt[NC];
  logic            c_zero_r  [NC];
  logic            c_zero_nxt[NC];
  amrd_pkg::side_t c_sd_r    [NC];
  amrd_pkg::side_t c_sd_nxt  [NC];

  always_comb begin
    amrd_pkg::ang_t x_in;
    amrd_pkg::ang_t y_in;
    amrd_pkg::ang_t t_in;
    for (int k = 0; k < NC; k++) begin
      if (k == 0) begin
        x_in          = amrd_pkg::CORDIC_K;
        y_in          = '0;
        t_in          = f_t_r;
        c_cneg_nxt[k] = f_cneg_r;
        c_root_nxt[k] = f_root_r;
        c_zero_nxt[k] = f_zero_r;
        c_sd_nxt[k]   = f_sd_r;
      end else begin
        x_in          = c_x_r[k-1];
        y_in          = c_y_r[k-1];
        t_in          = c_t_r[k-1];
        c_cneg_nxt[k] = c_cneg_r[k-1];
        c_root_nxt[k] = c_root_r[k-1];
        c_zero_nxt[k] = c_zero_r[k-1];
        c_sd_nxt[k]   = c_sd_r[k-1];
      end
      if (t_in >= 0) begin
        c_x_nxt[k] = x_in - (y_in >>> k);
        c_y_nxt[k] = y_in + (x_in >>> k);
        c_t_nxt[k] = t_in - amrd_pkg::ATAN_Q30[k];
      end else begin
        c_x_nxt[k] = x_in + (y_in >>> k);
        c_y_nxt[k] = y_in - (x_in >>> k);
        c_t_nxt[k] = t_in + amrd_pkg::ATAN_Q30[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_x_r    <= c_x_nxt;
      c_y_r    <= c_y_nxt;
      c_t_r    <= c_t_nxt;
      c_cneg_r <= c_cneg_nxt;
      c_root_r <= c_root_nxt;
      c_zero_r <= c_zero_nxt;
      c_sd_r   <= c_sd_nxt;
    end
  end

  // numerators sx*sin, sy*sin and the rounded cosine
  amrd_pkg::ang_t                  cos_signed;
  amrd_pkg::ang_t                  dz_full;
  logic signed [amrd_pkg::PRD_W-1:0] p_prx_r;
  logic signed [amrd_pkg::PRD_W-1:0] p_pry_r;
  logic signed [amrd_pkg::DZ_W-1:0]  p_dz_r;
  amrd_pkg::den_t                  p_den_r;
  logic                            p_zero_r;
  logic                            p_rej_r;

  assign cos_signed = c_cneg_r[NC-1] ? -c_x_r[NC-1] : c_x_r[NC-1];
  assign dz_full    = (cos_signed + amrd_pkg::ROUND_Q15) >>> 15;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_prx_r  <= c_sd_r[NC-1].sx * c_y_r[NC-1];
      p_pry_r  <= c_sd_r[NC-1].sy * c_y_r[NC-1];
      p_dz_r   <= dz_full[amrd_pkg::DZ_W-1:0];
      p_den_r  <= {c_root_r[NC-1], 14'h0000};
      p_zero_r <= c_zero_r[NC-1];
      p_rej_r  <= c_sd_r[NC-1].rej;
    end
  end

  // magnitudes plus half the divisor for round to nearest
  amrd_pkg::num_t                  magx;
  amrd_pkg::num_t                  magy;
  amrd_pkg::num_t                  n_numx_r;
  amrd_pkg::num_t                  n_numy_r;
  amrd_pkg::den_t                  n_den_r;
  logic                            n_negx_r;
  logic                            n_negy_r;
  logic signed [amrd_pkg::DZ_W-1:0]  n_dz_r;
  logic                            n_zero_r;
  logic                            n_rej_r;

  assign magx = p_prx_r[amrd_pkg::PRD_W-1] ? amrd_pkg::num_t'(-p_prx_r)
                                           : amrd_pkg::num_t'(p_prx_r);
  assign magy = p_pry_r[amrd_pkg::PRD_W-1] ? amrd_pkg::num_t'(-p_pry_r)
                                           : amrd_pkg::num_t'(p_pry_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      n_numx_r <= magx + amrd_pkg::NUM_W'(p_den_r >> 1);
      n_numy_r <= magy + amrd_pkg::NUM_W'(p_den_r >> 1);
      n_den_r  <= p_den_r;
      n_negx_r <= p_prx_r[amrd_pkg::PRD_W-1];
      n_negy_r <= p_pry_r[amrd_pkg::PRD_W-1];
      n_dz_r   <= p_dz_r;
      n_zero_r <= p_zero_r;
      n_rej_r  <= p_rej_r;
    end
  end

  // dividers for x and y, side fields delayed alongside
  amrd_pkg::quo_t quox;
  amrd_pkg::quo_t quoy;

  amrd_div u_div_x (
    .clk   (clk),
    .adv   (adv),
    .num_i (n_numx_r),
    .den_i (n_den_r),
    .quo_o (quox)
  );

  amrd_div u_div_y (
    .clk   (clk),
    .adv   (adv),
    .num_i (n_numy_r),
    .den_i (n_den_r),
    .quo_o (quoy)
  );

  logic                             d_negx_r [QUO_W];
  logic                             d_negy_r [QUO_W];
  logic signed [amrd_pkg::DZ_W-1:0] d_dz_r   [QUO_W];
  logic                             d_zero_r [QUO_W];
  logic                             d_rej_r  [QUO_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      d_negx_r[0] <= n_negx_r;
      d_negy_r[0] <= n_negy_r;
      d_dz_r[0]   <= n_dz_r;
      d_zero_r[0] <= n_zero_r;
      d_rej_r[0]  <= n_rej_r;
      for (int k = 1; k < QUO_W; k++) begin
        d_negx_r[k] <= d_negx_r[k-1];
        d_negy_r[k] <= d_negy_r[k-1];
        d_dz_r[k]   <= d_dz_r[k-1];
        d_zero_r[k] <= d_zero_r[k-1];
        d_rej_r[k]  <= d_rej_r[k-1];
      end
    end
  end

  // signs, mirror, flip and saturation into the output register
  logic signed [amrd_pkg::RES_W-1:0] qx;
  logic signed [amrd_pkg::RES_W-1:0] qy;
  logic signed [amrd_pkg::RES_W-1:0] vx;
  logic signed [amrd_pkg::RES_W-1:0] vy;
  logic signed [amrd_pkg::RES_W-1:0] vz_pre;
  logic signed [amrd_pkg::RES_W-1:0] vz;
  logic                              sgnx;

  always_comb begin
    qx     = {2'b00, quox};
    qy     = {2'b00, quoy};
    sgnx   = d_negx_r[QUO_W-1] ^ mirror_x_r ^ flip_r;
    vz_pre = d_zero_r[QUO_W-1] ? amrd_pkg::ONE_Q15 : d_dz_r[QUO_W-1];
    if (d_zero_r[QUO_W-1]) begin
      vx = '0;
      vy = '0;
    end else begin
      vx = sgnx ? -qx : qx;
      vy = d_negy_r[QUO_W-1] ? -qy : qy;
    end
    vz = flip_r ? -vz_pre : vz_pre;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (d_rej_r[QUO_W-1]) begin
        out_dir_x    <= '0;
        out_dir_y    <= '0;
        out_dir_z    <= amrd_pkg::DIR_MIN;
        out_rejected <= 1'b1;
      end else begin
        out_dir_x    <= amrd_pkg::sat_dir(vx);
        out_dir_y    <= amrd_pkg::sat_dir(vy);
        out_dir_z    <= amrd_pkg::sat_dir(vz);
        out_rejected <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/amrd_chk.sv =====
// amrd_chk: port-level checks on the ray direction block, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module amrd_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [15:0] out_dir_x,
  input wire logic signed [15:0] out_dir_y,
  input wire logic signed [15:0] out_dir_z,
  input wire logic               out_rejected
);

  // input is held back exactly when a result waits on a stalled output
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output back-pressure");

  // a stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dir_x) && $stable(out_dir_y)
      && $stable(out_dir_z) && $stable(out_rejected))
    else $error("stalled result changed");

  // a rejected point always carries the fixed backward direction
  a_rej_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_dir_x == 16'sd0 && out_dir_y == 16'sd0
      && out_dir_z == 16'sh8000)
    else $error("rejected point with wrong direction");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind angular_map_ray_direction amrd_chk u_amrd_chk (.*);

`default_nettype wire
